// File: src/mdl_pkg.sv
// Shared types, constants and a helper function for the moving dot renderer.
package mdl_pkg;

  localparam int MAX_DOTS = 4;
  localparam int MAX_TAIL = 14;
  localparam int DOT_W    = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HALF_LENGTH  = 3'd0,
    REG_TAIL_WIDTH   = 3'd1,
    REG_MOVE_PERIOD  = 3'd2,
    REG_COLOR_PERIOD = 3'd3,
    REG_DOT_COUNT    = 3'd4,
    REG_BASE_HUE     = 3'd5,
    REG_STRIP_MASK   = 3'd6,
    REG_ORIGIN_TIME  = 3'd7
  } cfg_reg_t;

  // divide jobs run on the shared divider
  typedef enum logic [2:0] {
    J_EMODC, // elapsed mod color period
    J_HUE,   // hue from color phase
    J_HC,    // hue change per LED
    J_EMODD, // elapsed mod move period
    J_CEN,   // head position
    J_SPC,   // copy spacing
    J_TAIL   // tail distance over tail width
  } div_job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PM_INIT,
    S_DIST,
    S_COEF,
    S_BRIGHT,
    S_CMUL,
    S_COUT,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    logic     div_cap;
    div_job_t job;
    logic     pm_step;
    logic     pix_dist;
    logic     pix_coef;
    logic     pix_bright;
    logic     cp_mul;
    logic     cp_out;
    logic     cp_next;
    logic     pos_next;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic c_zero;
    logic pm_ready;
    logic cp_last;
    logic pos_head;
  } dp_stat_t;

  // x mod 255 for x below 1020
  function automatic logic [7:0] mod255(input logic [9:0] x);
    logic [9:0] r;
    begin
      if (x >= 10'd765) r = x - 10'd765;
      else if (x >= 10'd510) r = x - 10'd510;
      else if (x >= 10'd255) r = x - 10'd255;
      else r = x;
      return r[7:0];
    end
  endfunction

endpackage

// File: src/mdl_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend and 24-bit divisor.
module mdl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dvd,
  input  logic [23:0] dvs,
  output logic        done,
  output logic [31:0] quot,
  output logic [23:0] rem
);
  logic [31:0] q_r, q_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [23:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [24:0] shifted, trial;

  // one restoring step
  always_comb begin
    shifted = {rem_r, q_r[31]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[24]) begin
      rem_nxt = trial[23:0];
      q_nxt   = {q_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[23:0];
      q_nxt   = {q_r[30:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;
endmodule

// File: src/mdl_ctrl.sv
// Controller state machine sequencing divides, tail positions and dot copies.
module mdl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mdl_pkg::dp_stat_t st,
  output mdl_pkg::dp_cmd_t  cmd
);
  import mdl_pkg::*;

  state_t   state_r, state_nxt;
  div_job_t job_r, job_nxt;

  // state and job registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= J_EMODC;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV_GO;
          job_nxt   = st.c_zero ? J_EMODD : J_EMODC;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (st.div_done) begin
          unique case (job_r)
            J_EMODC: begin job_nxt = J_HUE;   state_nxt = S_DIV_GO; end
            J_HUE:   begin job_nxt = J_HC;    state_nxt = S_DIV_GO; end
            J_HC:    begin job_nxt = J_EMODD; state_nxt = S_DIV_GO; end
            J_EMODD: begin job_nxt = J_CEN;   state_nxt = S_DIV_GO; end
            J_CEN:   begin job_nxt = J_SPC;   state_nxt = S_DIV_GO; end
            J_SPC:   state_nxt = S_PM_INIT;
            J_TAIL:  state_nxt = S_COEF;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PM_INIT: if (st.pm_ready) state_nxt = S_DIST;
      S_DIST: begin
        state_nxt = S_DIV_GO;
        job_nxt   = J_TAIL;
      end
      S_COEF:   state_nxt = S_BRIGHT;
      S_BRIGHT: state_nxt = S_CMUL;
      S_CMUL:   state_nxt = S_COUT;
      S_COUT:   state_nxt = S_WAIT;
      S_WAIT: begin
        if (out_ready) begin
          if (!st.cp_last) state_nxt = S_CMUL;
          else if (st.pos_head) state_nxt = S_IDLE;
          else state_nxt = S_DIST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.job        = job_r;
    in_ready       = (state_r == S_IDLE);
    out_valid      = (state_r == S_WAIT);
    unique case (state_r)
      S_IDLE:     cmd.load = in_valid;
      S_DIV_GO:   cmd.div_go = 1'b1;
      S_DIV_WAIT: cmd.div_cap = 1'b1;
      S_PM_INIT:  cmd.pm_step = !st.pm_ready;
      S_DIST:     cmd.pix_dist = 1'b1;
      S_COEF:     cmd.pix_coef = 1'b1;
      S_BRIGHT:   cmd.pix_bright = 1'b1;
      S_CMUL:     cmd.cp_mul = 1'b1;
      S_COUT:     cmd.cp_out = 1'b1;
      S_WAIT: begin
        cmd.cp_next  = out_ready && !st.cp_last;
        cmd.pos_next = out_ready && st.cp_last && !st.pos_head;
      end
      default: ;
    endcase
  end
endmodule

// File: src/mdl_dp.sv
// Datapath: configuration registers, shared divider, position, hue and brightness math.
module mdl_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [31:0]      in_now,
  input  mdl_pkg::dp_cmd_t  cmd,
  output mdl_pkg::dp_stat_t st,
  output logic [7:0]       out_led_index,
  output logic [7:0]       out_pixel_hue,
  output logic [7:0]       out_brightness,
  output logic             out_write_upper,
  output logic             out_write_lower,
  output logic             out_last
);
  import mdl_pkg::*;

  // configuration
  logic [7:0]  half_length_r, base_hue_r;
  logic [3:0]  tail_width_r;
  logic [15:0] move_period_r, color_period_r;
  logic [2:0]  dot_count_r;
  logic [1:0]  strip_mask_r;
  logic [31:0] origin_time_r;

  // per item state
  logic [31:0] e_r, hc_r;
  logic [15:0] rc_r, rd_r;
  logic [7:0]  hue_r, spc_r, pm_r, hpos_r, bright_r, sub_r, off_r, oh_r;
  logic [16:0] cen_r;
  logic signed [10:0] pos_r;
  logic [3:0]  cnt_r;
  logic [11:0] dist_r, q_r;
  logic [8:0]  coeff_r;
  logic        head_r;
  logic [DOT_W-1:0] i_r;

  // divider
  logic        div_done;
  logic [31:0] div_dvd, div_quot;
  logic [23:0] div_dvs, div_rem;

  // clamped settings and helpers
  logic [7:0]  m_c;
  logic [15:0] d_c;
  logic [3:0]  w_c;
  logic [2:0]  n_c;
  logic [23:0] cm_c, rdm_c, hue_num_c;
  logic [9:0]  head_c;
  logic [17:0] cen_up_c;
  logic signed [19:0] cen_s, pos_s, diff_s, adiff_s;
  logic [43:0] hd_prod;
  logic [39:0] oh_prod;
  logic [17:0] sq_c;
  logic [25:0] b_c;
  logic [9:0]  hsum_c, osum_c;
  logic [8:0]  idx_c;
  logic [10:0] pos0_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r  <= 8'd32;
      tail_width_r   <= 4'd10;
      move_period_r  <= 16'd10;
      color_period_r <= 16'd15;
      dot_count_r    <= 3'd1;
      base_hue_r     <= 8'd0;
      strip_mask_r   <= 2'd3;
      origin_time_r  <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_LENGTH:  half_length_r  <= cfg_data[7:0];
        REG_TAIL_WIDTH:   tail_width_r   <= cfg_data[3:0];
        REG_MOVE_PERIOD:  move_period_r  <= cfg_data[15:0];
        REG_COLOR_PERIOD: color_period_r <= cfg_data[15:0];
        REG_DOT_COUNT:    dot_count_r    <= cfg_data[2:0];
        REG_BASE_HUE:     base_hue_r     <= cfg_data[7:0];
        REG_STRIP_MASK:   strip_mask_r   <= cfg_data[1:0];
        REG_ORIGIN_TIME:  origin_time_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range settings fall back to the nearest legal value
  always_comb begin
    m_c = (half_length_r == 8'd0) ? 8'd1 : half_length_r;
    d_c = (move_period_r == 16'd0) ? 16'd1 : move_period_r;
    if (tail_width_r == 4'd0) w_c = 4'd1;
    else if (tail_width_r > 4'(MAX_TAIL)) w_c = 4'(MAX_TAIL);
    else w_c = tail_width_r;
    if (dot_count_r == 3'd0) n_c = 3'd1;
    else if (dot_count_r > 3'(MAX_DOTS)) n_c = 3'(MAX_DOTS);
    else n_c = dot_count_r;
  end

  assign cm_c      = color_period_r * m_c;
  assign rdm_c     = rd_r * m_c;
  assign hue_num_c = {rc_r, 8'd0} - {8'd0, rc_r};

  // divider operand select
  always_comb begin
    div_dvd = e_r;
    div_dvs = 24'd1;
    case (cmd.job)
      J_EMODC: begin div_dvd = e_r; div_dvs = {8'd0, color_period_r}; end
      J_HUE:   begin div_dvd = {8'd0, hue_num_c}; div_dvs = {8'd0, color_period_r}; end
      J_HC:    begin
        div_dvd = {d_c, 16'd0} - {8'd0, d_c, 8'd0};
        div_dvs = cm_c;
      end
      J_EMODD: begin div_dvd = e_r; div_dvs = {8'd0, d_c}; end
      J_CEN:   begin div_dvd = {rdm_c, 8'd0}; div_dvs = {8'd0, d_c}; end
      J_SPC:   begin div_dvd = {24'd0, m_c}; div_dvs = {21'd0, n_c}; end
      J_TAIL:  begin div_dvd = {20'd0, dist_r}; div_dvs = {20'd0, w_c}; end
      default: ;
    endcase
  end

  mdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // pixel math
  always_comb begin
    cen_up_c = {1'b0, cen_r} + 18'd255;
    head_c   = cen_up_c[17:8];
    cen_s    = {3'd0, cen_r};
    pos_s    = {pos_r[10], pos_r, 8'd0};
    diff_s   = cen_s - pos_s;
    adiff_s  = diff_s[19] ? -diff_s : diff_s;
    hd_prod  = hc_r * dist_r;
    oh_prod  = hc_r * off_r;
    sq_c     = coeff_r * coeff_r;
    b_c      = {sq_c, 8'd0} - {8'd0, sq_c};
    hsum_c   = {2'd0, hue_r} + 10'd510 - {2'd0, sub_r};
    osum_c   = {2'd0, hpos_r} + {2'd0, oh_r};
    idx_c    = {1'b0, pm_r} + {1'b0, off_r};
    pos0_c   = {3'd0, div_quot[15:8]} + {3'd0, m_c} - {7'd0, w_c};
  end

  // per item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r   <= in_now - origin_time_r;
      hue_r <= base_hue_r;
      hc_r  <= '0;
    end
    if (cmd.div_cap && div_done) begin
      case (cmd.job)
        J_EMODC: rc_r <= div_rem[15:0];
        J_HUE:   hue_r <= div_quot[7:0];
        J_HC:    hc_r <= div_quot;
        J_EMODD: rd_r <= div_rem[15:0];
        J_CEN: begin
          cen_r <= {1'b0, div_quot[15:0]} + {1'b0, m_c, 8'd0};
          pm_r  <= div_quot[15:8];
          pos_r <= $signed(pos0_c);
          cnt_r <= w_c;
        end
        J_SPC:   spc_r <= div_quot[7:0];
        J_TAIL:  q_r <= div_quot[11:0];
        default: ;
      endcase
    end
    // walk the tail start back, wrapping within the half strip
    if (cmd.pm_step) begin
      pm_r  <= (pm_r == 8'd0) ? m_c - 8'd1 : pm_r - 8'd1;
      cnt_r <= cnt_r - 4'd1;
    end
    if (cmd.pix_dist) begin
      dist_r <= adiff_s[11:0];
      head_r <= (pos_r == $signed({1'b0, head_c}));
    end
    if (cmd.pix_coef) begin
      if (head_r) coeff_r <= (dist_r >= 12'd256) ? 9'd0 : 9'd256 - dist_r[8:0];
      else coeff_r <= (q_r >= 12'd256) ? 9'd0 : 9'd256 - q_r[8:0];
      sub_r <= hd_prod[23:16];
    end
    if (cmd.pix_bright) begin
      bright_r <= b_c[23:16];
      hpos_r   <= head_r ? hue_r : mod255(hsum_c);
      off_r    <= '0;
      i_r      <= '0;
    end
    if (cmd.cp_mul) oh_r <= oh_prod[15:8];
    if (cmd.cp_out) begin
      out_led_index   <= (idx_c >= {1'b0, m_c}) ? 8'(idx_c - {1'b0, m_c}) : idx_c[7:0];
      out_pixel_hue   <= mod255(osum_c);
      out_brightness  <= bright_r;
      out_write_upper <= strip_mask_r[0];
      out_write_lower <= strip_mask_r[1];
      out_last        <= head_r && st.cp_last;
    end
    if (cmd.cp_next) begin
      off_r <= off_r + spc_r;
      i_r   <= i_r + 1'b1;
    end
    if (cmd.pos_next) begin
      pos_r <= pos_r + 11'sd1;
      pm_r  <= (pm_r == m_c - 8'd1) ? 8'd0 : pm_r + 8'd1;
    end
  end

  // status
  always_comb begin
    st.div_done = div_done;
    st.c_zero   = (color_period_r == 16'd0);
    st.pm_ready = (cnt_r == 4'd0);
    st.cp_last  = ({{(3 - DOT_W){1'b0}}, i_r} == n_c - 3'd1);
    st.pos_head = head_r;
  end
endmodule

// File: src/moving_dot_led_renderer_unit.sv
// Sequence: 6 divides per item (3 with color cycling off), then the tail start is placed,
// then per LED position one tail divide and one output write per dot copy, with output
// stalls holding the sequence.
// Throughput: one item at a time; the next time value is taken after the last write.
// Reset: synchronous active-low rst_n returns control to idle and configuration registers to defaults.
module moving_dot_led_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_led_index,
  output logic [7:0]  out_pixel_hue,
  output logic [7:0]  out_brightness,
  output logic        out_write_upper,
  output logic        out_write_lower,
  output logic        out_last
);
  import mdl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  mdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mdl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_now          (in_now),
    .cmd             (cmd),
    .st              (st),
    .out_led_index   (out_led_index),
    .out_pixel_hue   (out_pixel_hue),
    .out_brightness  (out_brightness),
    .out_write_upper (out_write_upper),
    .out_write_lower (out_write_lower),
    .out_last        (out_last)
  );
endmodule

// File: src/mdl_checker.sv
// Port-level checker for the renderer and its bind to the top level.
module mdl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_led_index,
  input logic [7:0]  out_pixel_hue,
  input logic [7:0]  out_brightness,
  input logic        out_last
);
  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_index)
      && $stable(out_pixel_hue) && $stable(out_brightness) && $stable(out_last))
    else $error("output item changed while stalled");

  // one time value at a time: no intake while writes are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // after the final write the block is free again
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not idle after final write");
endmodule

bind moving_dot_led_renderer_unit mdl_checker u_chk (.*);

// File: sim/moving_dot_led_renderer_unit_tb.sv
// Self-checking testbench for the moving dot LED renderer: directed and random time values.
`timescale 1ns / 100ps

module moving_dot_led_renderer_unit_tb;
  import mdl_pkg::*;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] pixel_hue;
    logic [7:0] brightness;
    logic       write_upper;
    logic       write_lower;
    logic       last;
  } led_write_t;

  // Predicts the LED writes for a time value and checks the writes that come out.
  class led_write_board;
    logic [7:0]  half_length;
    logic [3:0]  tail_width;
    logic [15:0] move_period;
    logic [15:0] color_period;
    logic [2:0]  dot_count;
    logic [7:0]  base_hue;
    logic [1:0]  strip_mask;
    logic [31:0] origin_time;
    led_write_t  pending_writes[$];
    int          mismatches;
    int          checked;

    function void set_defaults();
      half_length = 32; tail_width = 10; move_period = 10; color_period = 15;
      dot_count = 1; base_hue = 0; strip_mask = 3; origin_time = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_HALF_LENGTH:  half_length  = val[7:0];
        REG_TAIL_WIDTH:   tail_width   = val[3:0];
        REG_MOVE_PERIOD:  move_period  = val[15:0];
        REG_COLOR_PERIOD: color_period = val[15:0];
        REG_DOT_COUNT:    dot_count    = val[2:0];
        REG_BASE_HUE:     base_hue     = val[7:0];
        REG_STRIP_MASK:   strip_mask   = val[1:0];
        REG_ORIGIN_TIME:  origin_time  = val;
        default: ;
      endcase
    endfunction

    // Expand one time value into its LED writes.
    function void note_time(logic [31:0] now);
      longint m, dp, w, n, e, hue, hc, cen, head, tl, spacing, pos, diff, adist;
      longint coeff, bright, hpos, q, sub, pm, off, oh;
      led_write_t wr;
      int first;
      m = half_length ? half_length : 1;
      dp = move_period ? move_period : 1;
      w = tail_width == 0 ? 1 : (tail_width > MAX_TAIL ? MAX_TAIL : tail_width);
      n = dot_count == 0 ? 1 : (dot_count > MAX_DOTS ? MAX_DOTS : dot_count);
      e = longint'(32'(now - origin_time));
      if (color_period != 0) begin
        hue = (255 * (e % color_period)) / color_period;
        hc = (dp * 255 * 256) / (color_period * m);
      end else begin
        hue = base_hue;
        hc = 0;
      end
      cen = (((e % dp) * m * 256) / dp) + m * 256;
      head = (cen + 255) >>> 8;
      tl = (cen >>> 8) - w;
      spacing = m / n;
      first = pending_writes.size();
      for (pos = tl; pos <= head; pos++) begin
        diff = cen - pos * 256;
        adist = diff < 0 ? -diff : diff;
        if (pos == head) begin
          coeff = adist >= 256 ? 0 : 256 - adist;
          hpos = hue;
        end else begin
          q = adist / w;
          sub = ((hc * adist) >>> 16) & 255;
          coeff = q >= 256 ? 0 : 256 - q;
          hpos = (hue + 510 - sub) % 255;
        end
        bright = (255 * coeff * coeff) >>> 16;
        pm = pos % m;
        if (pm < 0) pm += m;
        for (longint i = 0; i < n; i++) begin
          off = spacing * i;
          oh = ((off * hc) >>> 8) & 255;
          wr.led_index = 8'((pm + off) % m);
          wr.pixel_hue = 8'((hpos + oh) % 255);
          wr.brightness = 8'(bright);
          wr.write_upper = strip_mask[0];
          wr.write_lower = strip_mask[1];
          wr.last = 1'b0;
          pending_writes.push_back(wr);
        end
      end
      if (pending_writes.size() > first)
        pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    function void check_write(led_write_t got);
      led_write_t want;
      checked++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected write %h", got);
        return;
      end
      want = pending_writes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("write mismatch: idx %0d/%0d hue %0d/%0d bright %0d/%0d up %b/%b lo %b/%b last %b/%b",
                   want.led_index, got.led_index, want.pixel_hue, got.pixel_hue,
                   want.brightness, got.brightness, want.write_upper, got.write_upper,
                   want.write_lower, got.write_lower, want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_now = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_led_index, out_pixel_hue, out_brightness;
  logic        out_write_upper, out_write_lower, out_last;

  led_write_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int times_sent = 0;

  always #5 clk = ~clk;

  moving_dot_led_renderer_unit dut (.*);

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_write({out_led_index, out_pixel_hue, out_brightness,
                           out_write_upper, out_write_lower, out_last});
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // write enable stays high across a burst; load_settings drops it at the end
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // valid stays high after an accept until the next idle cycle or drain
  task automatic send_time(logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now <= now;
    board.note_time(now);
    do @(posedge clk); while (!in_ready);
    times_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_settings(logic [7:0] m, logic [3:0] w, logic [15:0] d, logic [15:0] c,
                               logic [2:0] n, logic [7:0] bh, logic [1:0] sm, logic [31:0] org);
    write_reg(REG_HALF_LENGTH, m);
    write_reg(REG_TAIL_WIDTH, w);
    write_reg(REG_MOVE_PERIOD, d);
    write_reg(REG_COLOR_PERIOD, c);
    write_reg(REG_DOT_COUNT, n);
    write_reg(REG_BASE_HUE, bh);
    write_reg(REG_STRIP_MASK, sm);
    write_reg(REG_ORIGIN_TIME, org);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_settings();
    logic [7:0] m;
    m = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(2, 40));
    load_settings(m, 4'($urandom_range(15)), 16'($urandom), 16'($urandom),
                  3'($urandom_range(7)), 8'($urandom), 2'($urandom_range(3)), $urandom);
  endtask

  initial begin
    logic [31:0] t;
    board.set_defaults();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, time extremes, then edge settings
    send_time(32'h0);
    send_time(32'hFFFF_FFFF);
    send_time(32'd7);
    drain();
    load_settings(0, 0, 0, 0, 0, 8'hFF, 0, 32'hFFFF_FFFF); // zero every setting but base hue and origin time
    send_time(32'h0);
    send_time(32'hAAAA_5555);
    drain();
    load_settings(255, 15, 16'hFFFF, 16'hFFFF, 7, 8'h00, 1, 32'h8000_0000);
    send_time(32'h7FFF_FFFF);
    send_time(32'h5555_AAAA);
    drain();
    load_settings(2, 1, 1, 1, 4, 8'h80, 2, 0);
    send_time(32'd1);
    send_time(32'd2);
    drain();
    load_settings(3, 14, 16'd7, 16'd0, 3, 8'd200, 3, 32'd5);
    send_time(32'd3);
    send_time(32'd100);
    drain();

    // Long receiver hold-off while times keep coming
    hold_off = 400;
    send_time($urandom);
    send_time($urandom);
    send_time($urandom);
    drain();

    // Random phases with changing idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 14 : 0;
      for (int k = 0; k < 4; k++) begin
        random_settings();
        t = $urandom;
        for (int j = 0; j < 28; j++) begin
          t = ($urandom_range(3) == 0) ? $urandom : t + $urandom_range(40);
          send_time(t);
        end
        drain();
      end
    end

    $display("Sent %0d time values, checked %0d LED writes over edge and random settings.",
             times_sent, board.checked);
    if (board.mismatches == 0 && board.pending_writes.size() == 0) begin
      $display("moving_dot_led_renderer_unit_tb OK");
    end else begin
      $display("moving_dot_led_renderer_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #1_500_000_000;
    $display("moving_dot_led_renderer_unit_tb NOT OK");
    $finish;
  end

endmodule
